// ----- rtl/c2dig_pkg.sv -----
`timescale 1ns / 1ps
package c2dig_pkg;

	localparam int DEF_MAX_CHANNELS = 16;
	localparam int DEF_MAX_KERNEL   = 8;
	localparam int DEF_MAX_GRAD_MAP = 32;

	// Width of the size arithmetic; holds the largest map plus kernel.
	localparam int SZW = 10;

	localparam logic [1:0] CMD_WEIGHT = 2'd0;
	localparam logic [1:0] CMD_GRAD   = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [2:0] REG_NUM_OUT_CH = 3'd0;
	localparam logic [2:0] REG_NUM_IN_CH  = 3'd1;
	localparam logic [2:0] REG_KERN_ROWS  = 3'd2;
	localparam logic [2:0] REG_KERN_COLS  = 3'd3;
	localparam logic [2:0] REG_GRAD_ROWS  = 3'd4;
	localparam logic [2:0] REG_GRAD_COLS  = 3'd5;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [4:0] num_out_channels;
		logic [4:0] num_in_channels;
		logic [3:0] kernel_rows;
		logic [3:0] kernel_cols;
		logic [5:0] grad_rows;
		logic [5:0] grad_cols;
	} cfg_t;

	typedef struct packed {
		logic op;
		logic first;
		logic last;
		logic tap_ok;
		logic pos_ok;
	} ctrl_t;

	function automatic int idx_width(int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic logic [SZW-1:0] sat_size(logic [SZW-1:0] v, logic [SZW-1:0] maxv);
		logic [SZW-1:0] r;
		if (v == '0) begin
			r = SZW'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- rtl/c2dig_store.sv -----
`timescale 1ns / 1ps
module c2dig_store #(
	parameter int AW = 14,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/c2dig_seq.sv -----
`timescale 1ns / 1ps
module c2dig_seq #(
	parameter int MAX_CHANNELS = c2dig_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_KERNEL   = c2dig_pkg::DEF_MAX_KERNEL,
	parameter int MAX_GRAD_MAP = c2dig_pkg::DEF_MAX_GRAD_MAP,
	localparam int CW = c2dig_pkg::idx_width(MAX_CHANNELS),
	localparam int KW = c2dig_pkg::idx_width(MAX_KERNEL),
	localparam int GW = c2dig_pkg::idx_width(MAX_GRAD_MAP)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              cmd,
	input  logic [3:0]              in_chan,
	input  logic [5:0]              row,
	input  logic [5:0]              col,
	input  c2dig_pkg::cfg_t         cfg,
	output logic                    busy,
	output logic [2*CW+2*KW-1:0]    w_raddr,
	output logic [CW+2*GW-1:0]      g_raddr,
	output c2dig_pkg::ctrl_t        ctrl_s1
);

	import c2dig_pkg::*;

	state_t state_q, state_d;
	logic [CW-1:0] c_q;
	logic [KW-1:0] u_q, v_q;
	logic [3:0] ic_q;
	logic [5:0] row_q, col_q;
	logic single_q;

	logic [SZW-1:0] nc, nk, kh, kw, gh, gw;
	logic [SZW-1:0] ii, jj;
	logic accept_query, off_map;
	logic c_last, v_last, u_last, last;
	logic row_ok, col_ok;
	ctrl_t ctrl_d;

	assign nc = sat_size(SZW'(cfg.num_out_channels), SZW'(MAX_CHANNELS));
	assign nk = sat_size(SZW'(cfg.num_in_channels), SZW'(MAX_CHANNELS));
	assign kh = sat_size(SZW'(cfg.kernel_rows), SZW'(MAX_KERNEL));
	assign kw = sat_size(SZW'(cfg.kernel_cols), SZW'(MAX_KERNEL));
	assign gh = sat_size(SZW'(cfg.grad_rows), SZW'(MAX_GRAD_MAP));
	assign gw = sat_size(SZW'(cfg.grad_cols), SZW'(MAX_GRAD_MAP));

	assign accept_query = start && (state_q == ST_IDLE) && (cmd == CMD_QUERY);
	assign off_map = (SZW'(in_chan) >= nk) || (SZW'(row) >= gh + kh - SZW'(1))
		|| (SZW'(col) >= gw + kw - SZW'(1));

	assign c_last = (SZW'(c_q) == nc - SZW'(1));
	assign v_last = (SZW'(v_q) == kw - SZW'(1));
	assign u_last = (SZW'(u_q) == kh - SZW'(1));
	assign last = single_q || (c_last && v_last && u_last);

	// Gradient position under the current tap; negative values wrap to the top half.
	assign ii = SZW'(row_q) + SZW'(u_q) + SZW'(1) - kh;
	assign jj = SZW'(col_q) + SZW'(v_q) + SZW'(1) - kw;
	assign row_ok = !ii[SZW-1] && (ii < gh);
	assign col_ok = !jj[SZW-1] && (jj < gw);

	assign w_raddr = {c_q, CW'(ic_q), u_q, v_q};
	assign g_raddr = {c_q, ii[GW-1:0], jj[GW-1:0]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_query) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		ctrl_d = '0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_RUN: begin
				busy = 1'b1;
				ctrl_d.op = 1'b1;
				ctrl_d.first = (c_q == '0) && (u_q == '0) && (v_q == '0);
				ctrl_d.last = last;
				ctrl_d.tap_ok = !single_q && row_ok && col_ok;
				ctrl_d.pos_ok = !single_q;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctrl_s1 <= '0;
			c_q <= '0;
			u_q <= '0;
			v_q <= '0;
			single_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctrl_s1 <= ctrl_d;
			if (accept_query) begin
				c_q <= '0;
				u_q <= '0;
				v_q <= '0;
				single_q <= off_map;
			end else if ((state_q == ST_RUN) && !last) begin
				if (c_last) begin
					c_q <= '0;
					if (v_last) begin
						v_q <= '0;
						u_q <= u_q + KW'(1);
					end else begin
						v_q <= v_q + KW'(1);
					end
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_query) begin
			ic_q <= in_chan;
			row_q <= row;
			col_q <= col;
		end
	end

endmodule

// ----- rtl/c2dig_mac.sv -----
`timescale 1ns / 1ps
module c2dig_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  w_data,
	input  logic signed [15:0]  g_data,
	input  c2dig_pkg::ctrl_t    ctrl_s1,
	output logic [47:0]         acc_q,
	output logic                done,
	output logic                pos_ok
);

	import c2dig_pkg::*;

	logic signed [31:0] prod_s2;
	ctrl_t ctrl_s2;
	logic done_q, pos_q;

	always_ff @(posedge clk) begin
		prod_s2 <= ctrl_s1.tap_ok ? (w_data * g_data) : 32'sd0;
		if (ctrl_s2.op) begin
			acc_q <= (ctrl_s2.first ? 48'd0 : acc_q) + {{16{prod_s2[31]}}, prod_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			done_q <= 1'b0;
			pos_q <= 1'b0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			done_q <= ctrl_s2.op && ctrl_s2.last;
			if (ctrl_s2.op && ctrl_s2.last) begin
				pos_q <= ctrl_s2.pos_ok;
			end
		end
	end

	assign done = done_q;
	assign pos_ok = pos_q;

endmodule

// ----- rtl/conv2d_input_gradient_unit.sv -----
`timescale 1ns / 1ps
// Input-gradient unit for a 2D convolution layer. Weight and gradient writes never
// raise busy. A query raises busy while it sweeps kernel_rows * kernel_cols *
// num_out_channels taps (at most 1024 with the default sizes), one multiply-accumulate
// per cycle through a single 16x16 multiplier fed by one read port on each store; taps
// that fall off the gradient map are still swept and add zero. A query outside the full
// map sweeps no taps. The result appears after busy falls, through the ctrl_s2 and done
// registers, on done for exactly one cycle; the receiver cannot stall it, so it must take every result when shown.
module conv2d_input_gradient_unit #(
	parameter int MAX_CHANNELS = c2dig_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_KERNEL   = c2dig_pkg::DEF_MAX_KERNEL,
	parameter int MAX_GRAD_MAP = c2dig_pkg::DEF_MAX_GRAD_MAP
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic [3:0]          out_chan,
	input  logic [3:0]          in_chan,
	input  logic [5:0]          row,
	input  logic [5:0]          col,
	input  logic signed [15:0]  value,
	output logic                done,
	output logic signed [47:0]  grad_value,
	output logic                valid_position,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [5:0]          cfg_data
);

	import c2dig_pkg::*;

	localparam int CW = idx_width(MAX_CHANNELS);
	localparam int KW = idx_width(MAX_KERNEL);
	localparam int GW = idx_width(MAX_GRAD_MAP);
	localparam int WAW = 2 * CW + 2 * KW;
	localparam int GAW = CW + 2 * GW;

	cfg_t cfg_q;
	logic w_we, g_we, wr_accept;
	logic [WAW-1:0] w_waddr, w_raddr;
	logic [GAW-1:0] g_waddr, g_raddr;
	logic [15:0] w_rdata, g_rdata;
	logic [47:0] acc;
	ctrl_t ctrl_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_out_channels <= 5'd1;
			cfg_q.num_in_channels <= 5'd1;
			cfg_q.kernel_rows <= 4'd3;
			cfg_q.kernel_cols <= 4'd3;
			cfg_q.grad_rows <= 6'd32;
			cfg_q.grad_cols <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NUM_OUT_CH: cfg_q.num_out_channels <= cfg_data[4:0];
				REG_NUM_IN_CH:  cfg_q.num_in_channels <= cfg_data[4:0];
				REG_KERN_ROWS:  cfg_q.kernel_rows <= cfg_data[3:0];
				REG_KERN_COLS:  cfg_q.kernel_cols <= cfg_data[3:0];
				REG_GRAD_ROWS:  cfg_q.grad_rows <= cfg_data;
				REG_GRAD_COLS:  cfg_q.grad_cols <= cfg_data;
				default: ;
			endcase
		end
	end

	// Writes outside the stores are dropped.
	assign wr_accept = start && !busy;
	assign w_we = wr_accept && (cmd == CMD_WEIGHT)
		&& (SZW'(out_chan) < SZW'(MAX_CHANNELS)) && (SZW'(in_chan) < SZW'(MAX_CHANNELS))
		&& (SZW'(row) < SZW'(MAX_KERNEL)) && (SZW'(col) < SZW'(MAX_KERNEL));
	assign g_we = wr_accept && (cmd == CMD_GRAD)
		&& (SZW'(out_chan) < SZW'(MAX_CHANNELS))
		&& (SZW'(row) < SZW'(MAX_GRAD_MAP)) && (SZW'(col) < SZW'(MAX_GRAD_MAP));
	assign w_waddr = {CW'(out_chan), CW'(in_chan), KW'(row), KW'(col)};
	assign g_waddr = {CW'(out_chan), GW'(row), GW'(col)};

	c2dig_seq #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_GRAD_MAP(MAX_GRAD_MAP)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.in_chan(in_chan),
		.row(row),
		.col(col),
		.cfg(cfg_q),
		.busy(busy),
		.w_raddr(w_raddr),
		.g_raddr(g_raddr),
		.ctrl_s1(ctrl_s1)
	);

	c2dig_store #(
		.AW(WAW),
		.DW(16)
	) u_weight_store (
		.clk(clk),
		.we(w_we),
		.waddr(w_waddr),
		.wdata(value),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	c2dig_store #(
		.AW(GAW),
		.DW(16)
	) u_grad_store (
		.clk(clk),
		.we(g_we),
		.waddr(g_waddr),
		.wdata(value),
		.raddr(g_raddr),
		.rdata(g_rdata)
	);

	c2dig_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.w_data($signed(w_rdata)),
		.g_data($signed(g_rdata)),
		.ctrl_s1(ctrl_s1),
		.acc_q(acc),
		.done(done),
		.pos_ok(valid_position)
	);

	assign grad_value = $signed(acc);

	// Results of two queries can never land in adjacent cycles.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held for two cycles");

	// A query outside the map reports a zero sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_position) |-> (grad_value == 48'sd0))
		else $error("off-map query returned a nonzero sum");

	// Busy only rises on an accepted query.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (cmd == CMD_QUERY)))
		else $error("busy rose without a query request");

	// The result follows the end of the sweep through the read and multiply stages.
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> ##2 done)
		else $error("result missing after query sweep");

endmodule
